@@ rtl/core/line_sensor_centroid_error_assert.svh @@
// Assertion macros shared by the line-sensor block.
`ifndef LINE_SENSOR_CENTROID_ERROR_ASSERT_SVH
`define LINE_SENSOR_CENTROID_ERROR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define LSCE_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("lsce assertion failed");

// Condition in one cycle implies a condition in the next.
`define LSCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lsce next-cycle assertion failed");

`endif

@@ rtl/core/lsce_pkg.sv @@
package lsce_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int IDX_W       = $clog2(NUM_SENSORS);

    localparam logic [7:0]  ALL_WHITE      = 8'hFF;
    localparam logic [7:0]  ALL_BLACK      = 8'h00;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;

    // sum of weights spans -16..16, count 0..8
    localparam int SUM_W = 6;
    localparam int MAG_W = 5;
    localparam int CNT_W = 4;

    typedef struct packed {
        logic [7:0]  sensor_bits;
        logic [31:0] now_ms;
    } lsce_in_t;

    typedef struct packed {
        logic signed [3:0] position_error;
        logic              black_seen;
    } lsce_out_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } lsce_div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } lsce_div_rsp_t;

    // channel weights, channel 0 leftmost
    function automatic logic signed [3:0] chan_weight(input logic [IDX_W-1:0] idx);
        logic signed [3:0] w;
        case (idx)
            3'd0:    w = 4'sd7;
            3'd1:    w = 4'sd5;
            3'd2:    w = 4'sd3;
            3'd3:    w = 4'sd1;
            3'd4:    w = -4'sd1;
            3'd5:    w = -4'sd3;
            3'd6:    w = -4'sd5;
            3'd7:    w = -4'sd7;
            default: w = 4'sd0;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/lsce_div.sv @@
module lsce_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lsce_pkg::lsce_div_req_t req,
    output lsce_pkg::lsce_div_rsp_t rsp
);
    import lsce_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [MAG_W-1:0] rem_shift;
    logic [MAG_W:0]   diff;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg[MAG_W-2:0], quo_reg[MAG_W-1]};
        diff      = {1'b0, rem_shift} - {{(MAG_W+1-CNT_W){1'b0}}, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[MAG_W]) begin
                rem_next = diff[MAG_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/core/line_sensor_centroid_error.sv @@
// Line-sensor centroid and black debounce. Each transfer on s_ carries an
// 8-channel sample (bit 0 leftmost, 0 = black) and the millisecond time; one
// result transfer on m_ follows for every input. black_seen is 1 once black
// has stood for at least debounce_time ms, measured with 32-bit wrapping
// subtraction from the recorded start (0 = no start; an all-white sample
// clears it). position_error is the mean of the weights 7,5,3,1,-1,-3,-5,-7
// over the black channels, truncated toward zero, and 0 for an all-black or
// all-white sample. Timing: one item at a time. A sample is scanned one
// channel per cycle, then the restoring divider steps through load, 5
// quotient bits and done before m_valid rises (an all-black or all-white
// sample skips the divide); s_ready returns the cycle after the result
// transfer. debounce_time (reset 30) is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while idle; the block leaves it unchecked.
module line_sensor_centroid_error (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lsce_pkg::lsce_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lsce_pkg::lsce_out_t m_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import lsce_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [15:0]             debounce_reg;
    logic [31:0]             start_reg, start_next;
    logic [7:0]              bits_reg, bits_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    zero_reg, zero_next;   // force error to 0
    logic                    seen_reg, seen_next;
    logic                    div_go_reg, div_go_next;
    lsce_out_t               out_reg, out_next;

    logic                    in_xfer;
    logic [31:0]             start_eff;
    logic [31:0]             elapsed;
    logic [MAG_W-1:0]        mag;
    logic signed [3:0]       quo_s;
    lsce_div_req_t           div_req;
    lsce_div_rsp_t           div_rsp;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;
    assign in_xfer = s_valid && s_ready;

    // debounce: start latches on the first black sample; a start of 0 means unset
    assign start_eff = (start_reg == '0) ? s_data.now_ms : start_reg;
    assign elapsed   = s_data.now_ms - start_eff;

    // magnitude of the weight sum, |sum| <= 16
    assign mag   = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
    assign quo_s = $signed(div_rsp.quotient[3:0]);

    assign div_req.start    = div_go_reg;
    assign div_req.dividend = mag;
    assign div_req.divisor  = cnt_reg;

    lsce_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next  = state_reg;
        start_next  = start_reg;
        bits_next   = bits_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        zero_next   = zero_reg;
        seen_next   = seen_reg;
        div_go_next = 1'b0;
        out_next    = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    bits_next = s_data.sensor_bits;
                    idx_next  = '0;
                    sum_next  = '0;
                    cnt_next  = '0;
                    zero_next = (s_data.sensor_bits == ALL_WHITE) ||
                                (s_data.sensor_bits == ALL_BLACK);
                    if (s_data.sensor_bits != ALL_WHITE) begin
                        start_next = start_eff;
                        seen_next  = (elapsed >= {16'd0, debounce_reg});
                    end else begin
                        start_next = '0;
                        seen_next  = 1'b0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one channel per cycle through the weight adder
                if (!bits_reg[idx_reg]) begin
                    sum_next = sum_reg + SUM_W'(chan_weight(idx_reg));
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(NUM_SENSORS - 1)) begin
                    if (zero_reg) begin
                        out_next.position_error = 4'sd0;
                        out_next.black_seen     = seen_reg;
                        state_next              = ST_OUT;
                    end else begin
                        div_go_next = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    out_next.position_error = sum_reg[SUM_W-1] ? -quo_s : quo_s;
                    out_next.black_seen     = seen_reg;
                    state_next              = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            debounce_reg <= DEBOUNCE_RESET;
            start_reg    <= '0;
            div_go_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            start_reg  <= start_next;
            div_go_reg <= div_go_next;
            if (cfg_wr_en) begin
                debounce_reg <= cfg_wr_data;
            end
        end
        bits_reg <= bits_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
        seen_reg <= seen_next;
        out_reg  <= out_next;
    end

`include "line_sensor_centroid_error_assert.svh"

    `LSCE_ASSERT(a_in_out_exclusive, !(s_ready && m_valid))
    `LSCE_ASSERT(a_err_in_range, !m_valid || (m_data.position_error != 4'sb1000))
    `LSCE_ASSERT(a_forced_zero, !(m_valid && zero_reg) || (m_data.position_error == 4'sd0))
    `LSCE_ASSERT_NEXT(a_white_clears, in_xfer && (s_data.sensor_bits == ALL_WHITE),
                      (start_reg == '0) && !seen_reg)
    `LSCE_ASSERT_NEXT(a_div_only_in_div, div_go_reg, state_reg == ST_DIV)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for line_sensor_centroid_error.
// A behavioral predictor tracks the debounce start time and computes the
// weighted centroid for every accepted input transfer; the result monitor
// compares every output transfer against the oldest pending prediction.
module testbench;
    import lsce_pkg::*;

    // Generous bound for the whole run.
    localparam int CYCLE_LIMIT = 400000;
    // Quiet cycles after all pending results have arrived.
    localparam int TAIL_CYCLES = 20;
    // Long receiver hold used to back the block up.
    localparam int LONG_HOLD   = 400;
    // Mismatches printed in full; later ones are only counted.
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    lsce_in_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    lsce_out_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    line_sensor_centroid_error dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the debounce register and of the
    // recorded black start time (0 = nothing recorded).
    // ------------------------------------------------------------------
    logic [15:0] debounce_ms    = DEBOUNCE_RESET;
    logic [31:0] black_start_ms = '0;

    // Predicted results, oldest first; one per accepted sample.
    lsce_out_t   pending_results[$];

    int          fail_count      = 0;
    int          samples_sent    = 0;
    int          results_checked = 0;
    int          settings_written = 0;
    int          cycle_count     = 0;

    // Random idling is on for most of the run and off in the last part.
    logic        idle_en    = 1'b1;
    // One-cycle request to the receiver to hold m_ready low; hold_len sets how long.
    logic        hold_pulse = 1'b0;
    int          hold_len   = 0;
    int          stall_left = 0;

    // Predict the result for one sample and advance the debounce state.
    // Channel i weighs 7 - 2*i, so channel 0 (leftmost) is +7 and 7 is -7.
    function automatic lsce_out_t predict_line(input lsce_in_t item);
        lsce_out_t   res;
        logic [31:0] elapsed;
        int          sum;
        int          cnt;
        int          quo;
        res = '0;
        sum = 0;
        cnt = 0;
        if (item.sensor_bits != ALL_WHITE) begin
            // A start latched at time 0 stays "unset" and relatches later.
            if (black_start_ms == 32'd0)
                black_start_ms = item.now_ms;
            elapsed = item.now_ms - black_start_ms;   // wraps mod 2^32
            res.black_seen = (elapsed >= {16'd0, debounce_ms});
        end else begin
            black_start_ms = '0;
        end
        // All black and all white both force a zero error.
        if (item.sensor_bits != ALL_WHITE && item.sensor_bits != ALL_BLACK) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                if (!item.sensor_bits[i]) begin
                    sum += 7 - 2 * i;
                    cnt++;
                end
            end
            // Divide the magnitude so the quotient truncates toward zero.
            quo = ((sum < 0) ? -sum : sum) / cnt;
            if (sum < 0)
                quo = -quo;
            res.position_error = quo[3:0];
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Result side: checks each output transfer and drives m_ready with
    // random stall bursts, plus the long hold when requested. All values
    // are sampled at the edge, before the DUT's nonblocking updates land.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        lsce_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("result transfer with nothing pending: err=%0d seen=%0b",
                                           m_data.position_error, m_data.black_seen));
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.position_error !== want.position_error)
                        note_failure($sformatf("position_error expected %0d got %0d",
                                               want.position_error, m_data.position_error));
                    if (m_data.black_seen !== want.black_seen)
                        note_failure($sformatf("black_seen expected %0b got %0b",
                                               want.black_seen, m_data.black_seen));
                    results_checked++;
                end
            end
            if (hold_pulse)
                stall_left = hold_len;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                // random stall burst, this cycle included
                stall_left = $urandom_range(1, 13) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side. s_valid is left high after a transfer so a back-to-back
    // sample only updates the payload; it is lowered only for a gap or
    // when the sender goes quiet, never twice in one step.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [7:0] bits, input logic [31:0] now);
        lsce_in_t item;
        int       gap;
        item.sensor_bits = bits;
        item.now_ms      = now;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        // transfer happened at this edge
        pending_results.push_back(predict_line(item));
        samples_sent++;
    endtask

    // Sender goes quiet until every predicted result has arrived.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Register writes only while the block is idle.
    task automatic write_debounce(input logic [15:0] value);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        debounce_ms = value;
        settings_written++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset-value debounce, every single channel, truncation both signs,
    // all black / all white, start latched at time zero, time wrap.
    task automatic test_directed();
        send_sample(ALL_WHITE, 32'd100);
        send_sample(ALL_BLACK, 32'd100);     // start latched, elapsed 0
        send_sample(ALL_BLACK, 32'd129);     // one short of debounce
        send_sample(ALL_BLACK, 32'd130);     // exactly debounce
        for (int i = 0; i < NUM_SENSORS; i++)
            send_sample(~(8'd1 << i), 32'd131 + i);
        send_sample(8'hF4, 32'd140);         // ch 0,1,3: 13/3 -> 4
        send_sample(8'h2F, 32'd141);         // ch 4,6,7: -13/3 -> -4
        send_sample(8'h55, 32'd142);         // odd channels: -4/4 -> -1
        send_sample(ALL_WHITE, 32'd143);     // clears start
        send_sample(ALL_BLACK, 32'd0);       // latched at zero stays unset
        send_sample(8'hFE, 32'd5);           // relatches at 5
        send_sample(ALL_WHITE, 32'd6);
        send_sample(8'h7F, 32'hFFFF_FFF0);
        send_sample(8'h7F, 32'h0000_000E);   // 30 ms across the wrap
        send_sample(8'hAA, 32'hFFFF_FFFF);   // even channels: 4/4 -> 1
    endtask

    // Debounce at its extremes and just above zero.
    task automatic test_debounce_extremes();
        write_debounce(16'd0);
        send_sample(ALL_WHITE, 32'd50);
        send_sample(ALL_BLACK, 32'd0);       // zero debounce: seen at once
        send_sample(8'hE7, 32'd0);
        send_sample(8'hE7, 32'd1);
        write_debounce(16'hFFFF);
        send_sample(ALL_WHITE, 32'd0);
        send_sample(8'hF0, 32'd1000);
        send_sample(8'hF0, 32'd1000 + 32'd65534);
        send_sample(8'hF0, 32'd1000 + 32'd65535);
        write_debounce(16'd1);
        send_sample(ALL_WHITE, 32'd3);
        send_sample(8'h0F, 32'd7);
        send_sample(8'h0F, 32'd7);
        send_sample(8'h0F, 32'd8);
    endtask

    // Receiver holds off for a long stretch while samples keep coming,
    // so the block fills and stalls its input; then the sender drains.
    task automatic test_output_hold();
        logic [31:0] t;
        wait_all_results();
        t = $urandom;
        hold_len   <= LONG_HOLD;
        hold_pulse <= 1'b1;
        @(posedge aclk);
        hold_pulse <= 1'b0;
        for (int i = 0; i < 10; i++) begin
            t = t + $urandom_range(0, 12);
            send_sample(8'($urandom), t);
        end
        wait_all_results();
    endtask

    // Random phases, each under its own debounce setting. Most samples
    // follow a drifting line with increasing time; the rest are lost
    // line, crossings, and raw noise with random times.
    task automatic test_random();
        logic [15:0] deb;
        logic [31:0] t;
        logic [8:0]  run;
        int          pos;
        int          width;
        int          max_step;
        int          mode;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       deb = 16'd0;
                1:       deb = 16'hFFFF;
                2:       deb = DEBOUNCE_RESET;
                3:       deb = 16'($urandom);
                default: deb = 16'($urandom_range(0, 64));
            endcase
            // last phase runs without idling on either side
            if (phase == 6)
                idle_en <= 1'b0;
            write_debounce(deb);
            max_step = deb / 4 + 4;
            // phase 2 starts near the top so time wraps mid-phase
            t   = (phase == 2) ? 32'hFFFF_FF00 : $urandom;
            pos = $urandom_range(0, 7);
            for (int n = 0; n < 200; n++) begin
                mode = $urandom_range(0, 19);
                if (mode < 14) begin
                    pos   = pos + $urandom_range(0, 2) - 1;
                    pos   = (pos < 0) ? 0 : (pos > 7) ? 7 : pos;
                    width = $urandom_range(1, 3);
                    run   = ((9'd1 << width) - 9'd1) << pos;
                    t     = t + $urandom_range(0, max_step);
                    send_sample(~run[7:0], t);
                end else if (mode < 16) begin
                    t = t + $urandom_range(0, max_step);
                    send_sample(ALL_WHITE, t);
                end else if (mode == 16) begin
                    t = t + $urandom_range(0, max_step);
                    send_sample(ALL_BLACK, t);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       t = $urandom;
                        1:       t = 32'd0;
                        default: t = t + $urandom_range(0, max_step);
                    endcase
                    send_sample(8'($urandom), t);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed();
        test_debounce_extremes();
        test_output_hold();
        test_random();

        wait_all_results();
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d samples, %0d results checked, %0d debounce writes",
                 samples_sent, results_checked, settings_written);
        $display("incl. extremes, time wrap, zero-time start, long output hold; %0d failures",
                 fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
